>>> design/imhq_pkg.sv
package imhq_pkg;

  // Fixed field widths of the ports.
  localparam int KEY_W      = 8;
  localparam int PRI_IN_W   = 16;
  localparam int TOTAL_W    = 7;
  localparam int OP_W       = 2;

  // Default sizes.
  localparam int CAPACITY_DEF      = 64;
  localparam int KEY_SPACE_DEF     = 256;
  localparam int PRIORITY_BITS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DEC  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

endpackage

>>> design/imhq_ram.sv
module imhq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/indexed_min_heap_queue.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_operation, in_item_key, in_item_priority
// out_      output     out_valid / out_stall out_ok, out_min_key, out_min_priority,
//                                            out_entry_total
//
// Each item is taken in the idle state, then the sift: a move up reads the parent, then
// compares and writes; a move down reads the left child, then the right child if there is
// one, then compares and writes (two heap reads, one compare). A refused item goes straight
// to the done state, which waits for any stall on the output. The single read port of
// the heap memory is why the two children are read one after the other.
// Reset (rst_n, synchronous, active low) clears the count, the next free key and the
// per-key presence bits at once; the memories need no clearing pass.
// A result waits in the output register while a new item may already be taken.
module indexed_min_heap_queue #(
  parameter int CAPACITY      = imhq_pkg::CAPACITY_DEF,
  parameter int KEY_SPACE     = imhq_pkg::KEY_SPACE_DEF,
  parameter int PRIORITY_BITS = imhq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [imhq_pkg::OP_W-1:0]     in_operation,
  input  logic [imhq_pkg::KEY_W-1:0]    in_item_key,
  input  logic [imhq_pkg::PRI_IN_W-1:0] in_item_priority,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic [imhq_pkg::KEY_W-1:0]    out_min_key,
  output logic [imhq_pkg::PRI_IN_W-1:0] out_min_priority,
  output logic [imhq_pkg::TOTAL_W-1:0]  out_entry_total
);

  import imhq_pkg::*;

  localparam int SW  = $clog2(CAPACITY);       // heap slot index
  localparam int CW  = $clog2(CAPACITY + 1);   // entry count
  localparam int NW  = $clog2(KEY_SPACE + 1);  // next free key
  localparam int KIW = $clog2(KEY_SPACE);      // key index into the slot map
  localparam int PB  = PRIORITY_BITS;
  localparam int HW  = KEY_W + PB;             // heap entry: key above priority
  localparam int IW  = SW + 2;                 // child index before range check

  // The sequencer: one state per memory access step.
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_POP_RD = 10'b0000000010,
    ST_MAP_RD = 10'b0000000100,
    ST_DEC_RD = 10'b0000001000,
    ST_UP     = 10'b0000010000,
    ST_UP_CMP = 10'b0000100000,
    ST_DN     = 10'b0001000000,
    ST_DN_L   = 10'b0010000000,
    ST_DN_R   = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        nfk_r, nfk_nxt;
  logic [KEY_SPACE-1:0] present_r, present_nxt;
  logic [KEY_W-1:0]     root_key_r, root_key_nxt;
  logic [PB-1:0]        root_pri_r, root_pri_nxt;
  logic [KEY_W-1:0]     cur_key_r, cur_key_nxt;
  logic [PB-1:0]        cur_pri_r, cur_pri_nxt;
  logic [SW-1:0]        hole_r, hole_nxt;
  logic [KEY_W-1:0]     lft_key_r, lft_key_nxt;
  logic [PB-1:0]        lft_pri_r, lft_pri_nxt;
  logic                 ok_r, ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [KEY_W-1:0]     out_key_r, out_key_nxt;
  logic [PRI_IN_W-1:0]  out_pri_r, out_pri_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;

  // Heap memory and slot map ports.
  logic          h_we, h_re;
  logic [SW-1:0] h_wa, h_ra;
  logic [HW-1:0] h_wd, h_rd;
  logic          m_we, m_re;
  logic [KIW-1:0] m_wa, m_ra;
  logic [SW-1:0] m_wd, m_rd;

  logic [KEY_W-1:0] h_rd_key;
  logic [PB-1:0]    h_rd_pri;
  logic             in_acc;
  logic [KIW-1:0]   key_idx;
  logic [PB-1:0]    pri_in;
  logic [SW-1:0]    parent;
  logic [IW-1:0]    l_w, r_w;
  logic             has_l, has_r;
  logic [KEY_W-1:0] cl_key;
  logic [PB-1:0]    cl_pri;
  logic             take_l, take_r;

  imhq_ram #(.DEPTH(CAPACITY), .WIDTH(HW)) u_heap (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (h_wa),
    .wr_data (h_wd),
    .rd_en   (h_re),
    .rd_addr (h_ra),
    .rd_data (h_rd)
  );

  imhq_ram #(.DEPTH(KEY_SPACE), .WIDTH(SW)) u_map (
    .clk     (clk),
    .wr_en   (m_we),
    .wr_addr (m_wa),
    .wr_data (m_wd),
    .rd_en   (m_re),
    .rd_addr (m_ra),
    .rd_data (m_rd)
  );

  assign h_rd_key = h_rd[HW-1:PB];
  assign h_rd_pri = h_rd[PB-1:0];
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign key_idx  = KIW'(in_item_key);
  assign pri_in   = PB'(in_item_priority);

  // Tree navigation around the hole that the moving entry occupies.
  assign parent = SW'((hole_r - 1'b1) >> 1);
  assign l_w    = (IW'(hole_r) << 1) + IW'(1);
  assign r_w    = l_w + IW'(1);
  assign has_l  = l_w < IW'(cnt_r);
  assign has_r  = r_w < IW'(cnt_r);

  // Sift-down compare: strictly smaller child wins, the left one on a tie.
  assign cl_key = (state_r == ST_DN_R) ? lft_key_r : h_rd_key;
  assign cl_pri = (state_r == ST_DN_R) ? lft_pri_r : h_rd_pri;
  assign take_l = cl_pri < cur_pri_r;
  assign take_r = (state_r == ST_DN_R) && (h_rd_pri < (take_l ? cl_pri : cur_pri_r));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    nfk_nxt       = nfk_r;
    present_nxt   = present_r;
    root_key_nxt  = root_key_r;
    root_pri_nxt  = root_pri_r;
    cur_key_nxt   = cur_key_r;
    cur_pri_nxt   = cur_pri_r;
    hole_nxt      = hole_r;
    lft_key_nxt   = lft_key_r;
    lft_pri_nxt   = lft_pri_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_pri_nxt   = out_pri_r;
    out_total_nxt = out_total_r;
    h_we = 1'b0;
    h_wa = hole_r;
    h_wd = {cur_key_r, cur_pri_r};
    h_re = 1'b0;
    h_ra = '0;
    m_we = 1'b0;
    m_wa = KIW'(cur_key_r);
    m_wd = hole_r;
    m_re = 1'b0;
    m_ra = key_idx;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
          case (op_t'(in_operation))
            OP_PUSH: begin
              if ((32'(nfk_r) < KEY_SPACE) && (32'(in_item_key) == 32'(nfk_r)) &&
                  (cnt_r < CW'(CAPACITY))) begin
                ok_nxt               = 1'b1;
                cur_key_nxt          = in_item_key;
                cur_pri_nxt          = pri_in;
                hole_nxt             = SW'(cnt_r);
                cnt_nxt              = cnt_r + 1'b1;
                nfk_nxt              = nfk_r + 1'b1;
                present_nxt[key_idx] = 1'b1;
                state_nxt            = ST_UP;
              end
            end
            OP_POP: begin
              if (cnt_r != '0) begin
                ok_nxt                          = 1'b1;
                present_nxt[KIW'(root_key_r)] = 1'b0;
                cnt_nxt                         = cnt_r - 1'b1;
                if (cnt_r != CW'(1)) begin
                  h_re      = 1'b1;
                  h_ra      = SW'(cnt_r - 1'b1);
                  state_nxt = ST_POP_RD;
                end
              end
            end
            OP_DEC: begin
              if ((32'(in_item_key) < KEY_SPACE) && present_r[key_idx]) begin
                m_re        = 1'b1;
                cur_key_nxt = in_item_key;
                cur_pri_nxt = pri_in;
                state_nxt   = ST_MAP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAP_RD: begin
        hole_nxt  = m_rd;
        h_re      = 1'b1;
        h_ra      = m_rd;
        state_nxt = ST_DEC_RD;
      end
      ST_DEC_RD: begin
        if (cur_pri_r <= h_rd_pri) begin
          ok_nxt    = 1'b1;
          state_nxt = ST_UP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_POP_RD: begin
        cur_key_nxt = h_rd_key;
        cur_pri_nxt = h_rd_pri;
        hole_nxt    = '0;
        state_nxt   = ST_DN;
      end
      ST_UP: begin
        if (hole_r == '0) begin
          h_we      = 1'b1;
          m_we      = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          h_re      = 1'b1;
          h_ra      = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        h_we = 1'b1;
        m_we = 1'b1;
        if (h_rd_pri > cur_pri_r) begin
          h_wd      = h_rd;
          m_wa      = KIW'(h_rd_key);
          hole_nxt  = parent;
          state_nxt = ST_UP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DN: begin
        if (has_l) begin
          h_re      = 1'b1;
          h_ra      = SW'(l_w);
          state_nxt = ST_DN_L;
        end else begin
          h_we      = 1'b1;
          m_we      = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DN_L, ST_DN_R: begin
        lft_key_nxt = h_rd_key;
        lft_pri_nxt = h_rd_pri;
        if ((state_r == ST_DN_L) && has_r) begin
          h_re      = 1'b1;
          h_ra      = SW'(r_w);
          state_nxt = ST_DN_R;
        end else begin
          h_we = 1'b1;
          m_we = 1'b1;
          if (take_r) begin
            h_wd      = h_rd;
            m_wa      = KIW'(h_rd_key);
            hole_nxt  = SW'(r_w);
            state_nxt = ST_DN;
          end else if (take_l) begin
            h_wd      = {cl_key, cl_pri};
            m_wa      = KIW'(cl_key);
            hole_nxt  = SW'(l_w);
            state_nxt = ST_DN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_key_nxt   = (cnt_r != '0) ? root_key_r : '0;
          out_pri_nxt   = (cnt_r != '0) ? PRI_IN_W'(root_pri_r) : '0;
          out_total_nxt = TOTAL_W'(cnt_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // The root is mirrored in registers so the result needs no extra read.
    if (h_we && (h_wa == '0)) begin
      root_key_nxt = h_wd[HW-1:PB];
      root_pri_nxt = h_wd[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      nfk_r       <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      nfk_r       <= nfk_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
    root_key_r  <= root_key_nxt;
    root_pri_r  <= root_pri_nxt;
    cur_key_r   <= cur_key_nxt;
    cur_pri_r   <= cur_pri_nxt;
    hole_r      <= hole_nxt;
    lft_key_r   <= lft_key_nxt;
    lft_pri_r   <= lft_pri_nxt;
    ok_r        <= ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_key_r   <= out_key_nxt;
    out_pri_r   <= out_pri_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_min_key      = out_key_r;
  assign out_min_priority = out_pri_r;
  assign out_entry_total  = out_total_r;

endmodule
